// ===== design/aod_pkg.sv =====
package aod_pkg;

  // Default widths of the sample and of the envelope fraction
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 24;

  // Fixed field widths
  localparam int COUNT_BITS      = 16;
  localparam int STRENGTH_BITS   = 16;
  localparam int SAMPLE_NUM_BITS = 48;
  localparam int SEQ_BITS        = 32;
  localparam int CFG_DATA_BITS   = 16;
  localparam int CFG_INDEX_BITS  = 1;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_REFRACTORY = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE    = 1'b1;

  // Register reset values
  localparam logic [COUNT_BITS-1:0] REFRACTORY_RESET = 16'd4320;
  localparam logic [COUNT_BITS-1:0] RELEASE_RESET    = 16'd1200;

  // Tracker coefficients, Q0.24 rounded to nearest
  localparam int COEF_BITS = 24;
  localparam logic [COEF_BITS-1:0] COEF_FAST_UP   = 24'd5872026;
  localparam logic [COEF_BITS-1:0] COEF_FAST_DOWN = 24'd335544;
  localparam logic [COEF_BITS-1:0] COEF_SLOW      = 24'd50332;
  localparam logic [COEF_BITS-1:0] COEF_NOISE     = 24'd1678;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic en;    // take a partial product this cycle
    logic high;  // upper half of the operand, add onto the accumulator
  } mac_ctl_t;

endpackage

// ===== design/aod_mac.sv =====
module aod_mac #(
  parameter int ENV_BITS = aod_pkg::SAMPLE_BITS_DEF + aod_pkg::FRACTION_BITS_DEF + 1
) (
  input  logic                         clk,
  input  aod_pkg::mac_ctl_t            ctl,
  input  logic [ENV_BITS-1:0]          operand,
  input  logic [aod_pkg::COEF_BITS-1:0] coef,
  output logic [ENV_BITS-1:0]          step
);

  localparam int CB       = aod_pkg::COEF_BITS;
  localparam int LO_BITS  = (ENV_BITS + 1) / 2;
  localparam int PROD_BITS = LO_BITS + CB;
  localparam int ACC_BITS = ENV_BITS + CB;

  logic [LO_BITS-1:0]   part;
  logic [PROD_BITS-1:0] prod;
  logic [ACC_BITS-1:0]  acc;

  // Two partial products: low half first, then the high half shifted up
  always_comb begin
    part = ctl.high ? LO_BITS'(operand >> LO_BITS) : operand[LO_BITS-1:0];
    prod = PROD_BITS'(part) * PROD_BITS'(coef);
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.high) begin
        acc <= acc + (ACC_BITS'(prod) << LO_BITS);
      end else begin
        acc <= ACC_BITS'(prod);
      end
    end
  end

  // floor(operand * coef / 2^24); never above the operand
  assign step = acc[ACC_BITS-1:CB];

endmodule

// ===== design/audio_onset_detector_core.sv =====
// Audio onset detector. Each input transaction carries one signed sample; each
// sample gives exactly one result transaction with the onset flag, the onset
// strength (integer part of the fast envelope, saturated to 16 bits, zero
// when there is no onset), the running sample number and the onset count.
// The flux |sample - previous sample| drives a fast envelope, a slow envelope
// and a noise floor that adapts only while the slow envelope is below the
// quiet level. All three trackers share one multiply-accumulate unit that
// forms each tracker step from two partial products, one tracker after
// another; the noise floor step is skipped while the slow envelope is above
// the quiet level, and the noise floor then holds. The block
// takes no new sample while one is in work; a finished result sits in the
// output register, and the next sample is accepted while it waits. The
// register refractory_samples (index 0) sets the minimum spacing of onsets,
// release_samples (index 1) the settled time needed before re-arming; write
// them only while the block is idle. Reset is synchronous and active high.
module audio_onset_detector_core #(
  parameter int SAMPLE_BITS   = aod_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = aod_pkg::FRACTION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_write_enable,
  input  logic [aod_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [aod_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  // sample channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 attack_detected,
  output logic [aod_pkg::STRENGTH_BITS-1:0]    attack_strength,
  output logic [aod_pkg::SAMPLE_NUM_BITS-1:0]  sample_number,
  output logic [aod_pkg::SEQ_BITS-1:0]         attack_sequence
);

  localparam int ENV_BITS   = SAMPLE_BITS + FRACTION_BITS + 1;
  localparam int N7_BITS    = ENV_BITS + 3;
  localparam int THR_BITS   = ENV_BITS + 2;
  localparam int CMP_BITS   = ENV_BITS + 7;
  localparam int FULL_SHIFT = SAMPLE_BITS - 1 + FRACTION_BITS;
  localparam int CNT        = aod_pkg::COUNT_BITS;
  localparam int CB         = aod_pkg::COEF_BITS;

  // Quiet level 0.012 and minimum threshold 0.0015 of full scale
  localparam logic [63:0] QUIET_WIDE = (64'd12 << FULL_SHIFT) / 64'd1000;
  localparam logic [63:0] MIN_WIDE   = (64'd15 << FULL_SHIFT) / 64'd10000;
  localparam logic [ENV_BITS-1:0] QUIET_LEVEL   = QUIET_WIDE[ENV_BITS-1:0];
  localparam logic [THR_BITS-1:0] MIN_THRESHOLD = MIN_WIDE[THR_BITS-1:0];
  localparam logic [CNT-1:0]      COUNT_MAX     = '1;
  localparam logic [63:0]         STRENGTH_MAX  = 64'hFFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_UPDATE,
    ST_SCALE,
    ST_THRESH,
    ST_COMPARE,
    ST_DECIDE
  } state_t;

  typedef enum logic [1:0] {
    TRK_FAST,
    TRK_SLOW,
    TRK_NOISE
  } tracker_t;

  state_t   state;
  tracker_t trk;

  // configuration registers
  logic [CNT-1:0] refractory_samples;
  logic [CNT-1:0] release_samples;

  // detector state
  logic signed [SAMPLE_BITS-1:0] previous_sample;
  logic [ENV_BITS-1:0] fast_envelope;
  logic [ENV_BITS-1:0] slow_envelope;
  logic [ENV_BITS-1:0] noise_floor;
  logic [CNT-1:0]      since_onset;
  logic [CNT-1:0]      settled_count;
  logic                armed;
  logic [aod_pkg::SAMPLE_NUM_BITS-1:0] sample_counter;
  logic [aod_pkg::SEQ_BITS-1:0]        onset_counter;

  // per-sample working registers
  logic [ENV_BITS-1:0] flux_fx;
  logic [ENV_BITS-1:0] diff;
  logic                dir_up;
  logic [CB-1:0]       coef;
  logic [N7_BITS-1:0]  noise7;
  logic [CMP_BITS-1:0] fast20;
  logic [N7_BITS-1:0]  fast5;
  logic [N7_BITS-1:0]  slow6;
  logic [THR_BITS-1:0] threshold;
  logic                settled;
  logic                sharp_rise;

  // combinational helpers
  logic signed [SAMPLE_BITS:0] sample_delta;
  logic [SAMPLE_BITS-1:0]      flux;
  logic [ENV_BITS-1:0]         env_cur;
  logic [ENV_BITS-1:0]         tgt_cur;
  logic                        tgt_ge;
  logic [ENV_BITS-1:0]         env_new;
  logic [ENV_BITS-1:0]         step;
  logic [THR_BITS-1:0]         noise35;
  logic [CMP_BITS-1:0]         thr17;
  logic                        refractory_done;
  logic [CNT-1:0]              settled_inc;
  logic [CNT-1:0]              settled_next;
  logic                        armed_next;
  logic                        onset;
  logic [63:0]                 whole;
  logic [aod_pkg::STRENGTH_BITS-1:0] strength;
  logic                        out_free;
  aod_pkg::mac_ctl_t           mac_ctl;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // Flux from the new sample
  always_comb begin
    sample_delta = (SAMPLE_BITS+1)'(sample) - (SAMPLE_BITS+1)'(previous_sample);
    flux = sample_delta[SAMPLE_BITS] ? SAMPLE_BITS'(-sample_delta)
                                     : sample_delta[SAMPLE_BITS-1:0];
  end

  // Pick the tracker the shared unit works on
  always_comb begin
    case (trk)
      TRK_FAST: begin
        env_cur = fast_envelope;
        tgt_cur = flux_fx;
      end
      TRK_SLOW: begin
        env_cur = slow_envelope;
        tgt_cur = flux_fx;
      end
      TRK_NOISE: begin
        env_cur = noise_floor;
        tgt_cur = slow_envelope;
      end
      default: begin
        env_cur = fast_envelope;
        tgt_cur = flux_fx;
      end
    endcase
    tgt_ge  = (tgt_cur >= env_cur);
    env_new = dir_up ? env_cur + step : env_cur - step;
  end

  always_comb begin
    mac_ctl.en   = (state == ST_MUL_LO) || (state == ST_MUL_HI);
    mac_ctl.high = (state == ST_MUL_HI);
  end

  aod_mac #(
    .ENV_BITS(ENV_BITS)
  ) u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .operand (diff),
    .coef    (coef),
    .step    (step)
  );

  // Threshold pieces and the arm / onset decision
  always_comb begin
    noise35 = THR_BITS'(noise7 >> 1);
    thr17   = (CMP_BITS'(threshold) << 4) + CMP_BITS'(threshold);

    refractory_done = (since_onset >= refractory_samples);
    settled_inc = (settled_count == COUNT_MAX) ? COUNT_MAX : settled_count + 1'b1;
    settled_next = settled_count;
    armed_next   = armed;
    if (!armed) begin
      settled_next = settled ? settled_inc : '0;
      if ((settled_next >= release_samples) && refractory_done) begin
        armed_next   = 1'b1;
        settled_next = '0;
      end
    end
    onset = armed_next && sharp_rise && refractory_done;
    if (onset) begin
      armed_next   = 1'b0;
      settled_next = '0;
    end

    whole    = 64'(fast_envelope >> FRACTION_BITS);
    strength = (whole > STRENGTH_MAX) ? '1 : whole[aod_pkg::STRENGTH_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      trk                <= TRK_FAST;
      refractory_samples <= aod_pkg::REFRACTORY_RESET;
      release_samples    <= aod_pkg::RELEASE_RESET;
      previous_sample    <= '0;
      fast_envelope      <= '0;
      slow_envelope      <= '0;
      noise_floor        <= '0;
      since_onset        <= '0;
      settled_count      <= '0;
      armed              <= 1'b0;
      sample_counter     <= '0;
      onset_counter      <= '0;
      out_valid          <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_write_enable) begin
        case (cfg_index)
          aod_pkg::REG_REFRACTORY: refractory_samples <= cfg_data;
          aod_pkg::REG_RELEASE:    release_samples    <= cfg_data;
          default: ;
        endcase
      end

      // drop the result once taken, unless a new one replaces it this cycle
      if (out_valid && out_ready && (state != ST_DECIDE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            previous_sample <= sample;
            flux_fx         <= ENV_BITS'(flux) << FRACTION_BITS;
            sample_counter  <= sample_counter + 1'b1;
            if (since_onset != COUNT_MAX) begin
              since_onset <= since_onset + 1'b1;
            end
            trk   <= TRK_FAST;
            state <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          // noise floor holds while the slow envelope is loud
          if ((trk == TRK_NOISE) && !(slow_envelope < QUIET_LEVEL)) begin
            state <= ST_SCALE;
          end else begin
            dir_up <= tgt_ge;
            diff   <= tgt_ge ? tgt_cur - env_cur : env_cur - tgt_cur;
            case (trk)
              TRK_FAST:  coef <= tgt_ge ? aod_pkg::COEF_FAST_UP : aod_pkg::COEF_FAST_DOWN;
              TRK_SLOW:  coef <= aod_pkg::COEF_SLOW;
              TRK_NOISE: coef <= aod_pkg::COEF_NOISE;
              default:   coef <= aod_pkg::COEF_SLOW;
            endcase
            state <= ST_MUL_LO;
          end
        end
        ST_MUL_LO: begin
          state <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          // move the tracker toward its target, then advance to the next one
          case (trk)
            TRK_FAST: begin
              fast_envelope <= env_new;
              trk           <= TRK_SLOW;
              state         <= ST_DIFF;
            end
            TRK_SLOW: begin
              slow_envelope <= env_new;
              trk           <= TRK_NOISE;
              state         <= ST_DIFF;
            end
            TRK_NOISE: begin
              noise_floor <= env_new;
              state       <= ST_SCALE;
            end
            default: begin
              state <= ST_SCALE;
            end
          endcase
        end
        ST_SCALE: begin
          noise7 <= (N7_BITS'(noise_floor) << 3) - N7_BITS'(noise_floor);
          fast20 <= (CMP_BITS'(fast_envelope) << 4) + (CMP_BITS'(fast_envelope) << 2);
          fast5  <= (N7_BITS'(fast_envelope) << 2) + N7_BITS'(fast_envelope);
          slow6  <= (N7_BITS'(slow_envelope) << 2) + (N7_BITS'(slow_envelope) << 1);
          state  <= ST_THRESH;
        end
        ST_THRESH: begin
          threshold <= (noise35 > MIN_THRESHOLD) ? noise35 : MIN_THRESHOLD;
          state     <= ST_COMPARE;
        end
        ST_COMPARE: begin
          settled    <= (fast20 < thr17) || (fast5 < slow6);
          sharp_rise <= (THR_BITS'(fast_envelope) > threshold) &&
                        ((ENV_BITS+1)'(fast_envelope) > ((ENV_BITS+1)'(slow_envelope) << 1));
          state      <= ST_DECIDE;
        end
        ST_DECIDE: begin
          // hold here until the output register is free
          if (out_free) begin
            armed         <= armed_next;
            settled_count <= settled_next;
            if (onset) begin
              since_onset   <= '0;
              onset_counter <= onset_counter + 1'b1;
            end
            out_valid       <= 1'b1;
            attack_detected <= onset;
            attack_strength <= onset ? strength : '0;
            sample_number   <= sample_counter;
            attack_sequence <= onset ? onset_counter + 1'b1 : onset_counter;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/aod_checker.sv =====
module aod_checker #(
  parameter int SAMPLE_BITS = aod_pkg::SAMPLE_BITS_DEF
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic signed [SAMPLE_BITS-1:0]       sample,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                attack_detected,
  input logic [aod_pkg::STRENGTH_BITS-1:0]   attack_strength,
  input logic [aod_pkg::SAMPLE_NUM_BITS-1:0] sample_number,
  input logic [aod_pkg::SEQ_BITS-1:0]        attack_sequence
);

  // one sample at a time: busy right after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a sample is in work");

  // a waiting sample holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(sample))
    else $error("waiting sample changed");

  // a fresh result only follows a busy period
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a sample in work");

  // strength is reported only with an onset
  a_strength_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !attack_detected |-> attack_strength == '0)
    else $error("nonzero strength without an onset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_number) &&
      $stable(attack_sequence) && $stable(attack_detected))
    else $error("stalled result changed");

endmodule

bind audio_onset_detector_core aod_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_aod_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .sample          (sample),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .attack_detected (attack_detected),
  .attack_strength (attack_strength),
  .sample_number   (sample_number),
  .attack_sequence (attack_sequence)
);
